/* src/kwi_pkg.sv */
// types, constants and codes shared by the keyframe weight interpolator
package kwi_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int KEY_IDX_W = $clog2(MAX_KEYS);
    localparam int KEY_CNT_W = $clog2(MAX_KEYS + 1);
    localparam int TICK_W    = 32;
    localparam int WEIGHT_W  = 20;
    localparam int PROD_W    = TICK_W + WEIGHT_W;
    localparam int DIV_STEPS = WEIGHT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    typedef logic [KEY_IDX_W-1:0] key_idx_t;
    typedef logic [KEY_CNT_W-1:0] key_cnt_t;
    typedef logic [TICK_W-1:0]    tick_t;
    typedef logic [WEIGHT_W-1:0]  weight_t;
    typedef logic [PROD_W-1:0]    prod_t;
    typedef logic [STEP_W-1:0]    step_t;
    typedef logic [Q_PTR_W-1:0]   q_ptr_t;
    typedef logic [Q_CNT_W-1:0]   q_cnt_t;

    localparam key_cnt_t KEY_CNT_MAX = key_cnt_t'(MAX_KEYS);
    localparam step_t    STEP_INIT   = step_t'(DIV_STEPS);
    localparam q_ptr_t   Q_PTR_LAST  = q_ptr_t'(Q_DEPTH - 1);
    localparam q_cnt_t   Q_CNT_FULL  = q_cnt_t'(Q_DEPTH);
    localparam weight_t  WEIGHT_FULL = weight_t'(1000000);

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_ORDER = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_SAMPLE,
        OP_NOP
    } op_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SRCH,
        BK_CMP,
        BK_UP,
        BK_LO,
        BK_MUL,
        BK_DIV,
        BK_ADJ,
        BK_FINISH
    } bk_state_t;

    typedef struct packed {
        logic [1:0] cmd;
        tick_t      tick;
        weight_t    weight;
    } cmd_item_t;

    typedef struct packed {
        weight_t    sampled_weight;
        logic [1:0] status;
    } res_item_t;

    typedef struct packed {
        op_t     op;
        tick_t   tick;
        weight_t weight;
    } op_item_t;

endpackage

/* src/kwi_front.sv */
// front end: takes command transfers, decodes them and clamps the weight
module kwi_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  kwi_pkg::cmd_item_t cmd_data,
    input  logic               q_full,
    output logic               q_push,
    output kwi_pkg::op_item_t  q_push_item
);

    logic              stage_valid_reg;
    kwi_pkg::op_item_t stage_reg;
    kwi_pkg::op_item_t decoded;

    always_comb
    begin
        decoded.tick   = cmd_data.tick;
        decoded.weight = (cmd_data.weight > kwi_pkg::WEIGHT_FULL) ?
                         kwi_pkg::WEIGHT_FULL : cmd_data.weight;
        case (cmd_data.cmd)
            kwi_pkg::CMD_CLEAR:  decoded.op = kwi_pkg::OP_CLEAR;
            kwi_pkg::CMD_APPEND: decoded.op = kwi_pkg::OP_APPEND;
            kwi_pkg::CMD_SAMPLE: decoded.op = kwi_pkg::OP_SAMPLE;
            default:             decoded.op = kwi_pkg::OP_NOP;
        endcase
    end

    assign cmd_stall   = stage_valid_reg && q_full;
    assign q_push      = stage_valid_reg && !q_full;
    assign q_push_item = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            stage_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd_stall && cmd_valid)
        begin
            stage_reg <= decoded;
        end
    end

endmodule

/* src/kwi_fifo.sv */
// short command queue between the front end and the back end
module kwi_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  kwi_pkg::op_item_t push_item,
    output logic              full,
    input  logic              pop,
    output kwi_pkg::op_item_t head_item,
    output logic              empty
);

    kwi_pkg::op_item_t q_mem [kwi_pkg::Q_DEPTH];
    kwi_pkg::q_ptr_t   wr_ptr_reg, wr_ptr_next;
    kwi_pkg::q_ptr_t   rd_ptr_reg, rd_ptr_next;
    kwi_pkg::q_cnt_t   cnt_reg, cnt_next;

    assign full      = (cnt_reg == kwi_pkg::Q_CNT_FULL);
    assign empty     = (cnt_reg == '0);
    assign head_item = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == kwi_pkg::Q_PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == kwi_pkg::Q_PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty) else $error("queue pop while empty");

endmodule

/* src/kwi_back.sv */
// back end: key store, binary search, serial divider and result register
module kwi_back (
    input  logic               clk,
    input  logic               rst_n,
    input  kwi_pkg::op_item_t  head_item,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               res_valid,
    input  logic               res_stall,
    output kwi_pkg::res_item_t res_data
);

    kwi_pkg::tick_t   key_ticks_mem   [kwi_pkg::MAX_KEYS];
    kwi_pkg::weight_t key_weights_mem [kwi_pkg::MAX_KEYS];

    kwi_pkg::bk_state_t state_reg, state_next;
    kwi_pkg::key_cnt_t  key_count_reg, key_count_next;
    kwi_pkg::tick_t     last_tick_reg, last_tick_next;
    kwi_pkg::tick_t     qtick_reg, qtick_next;
    kwi_pkg::key_cnt_t  lo_reg, lo_next;
    kwi_pkg::key_cnt_t  hi_reg, hi_next;
    kwi_pkg::key_cnt_t  mid_reg, mid_next;
    kwi_pkg::key_cnt_t  mid_c;
    kwi_pkg::tick_t     hi_tick_reg, hi_tick_next;
    kwi_pkg::weight_t   hi_weight_reg, hi_weight_next;
    kwi_pkg::tick_t     span_reg, span_next;
    kwi_pkg::tick_t     elapsed_reg, elapsed_next;
    kwi_pkg::weight_t   mag_reg, mag_next;
    logic               neg_reg, neg_next;
    kwi_pkg::weight_t   left_reg, left_next;
    kwi_pkg::tick_t     rem_reg, rem_next;
    kwi_pkg::weight_t   dvd_reg, dvd_next;
    kwi_pkg::weight_t   quo_reg, quo_next;
    kwi_pkg::step_t     step_reg, step_next;
    kwi_pkg::res_item_t res_reg, res_next;
    kwi_pkg::res_item_t out_reg;
    logic               out_valid_reg;
    logic               out_load;

    logic               rd_en;
    kwi_pkg::key_idx_t  rd_addr;
    kwi_pkg::tick_t     rd_tick_reg;
    kwi_pkg::weight_t   rd_weight_reg;
    logic               wr_en;
    kwi_pkg::key_idx_t  wr_addr;

    kwi_pkg::prod_t      prod;
    logic [kwi_pkg::TICK_W:0] trial;
    logic                fits;

    assign mid_c = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign prod  = mag_reg * elapsed_reg;
    assign trial = {rem_reg, dvd_reg[kwi_pkg::WEIGHT_W-1]};
    assign fits  = (trial >= {1'b0, span_reg});

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;
    assign q_pop     = (state_reg == kwi_pkg::BK_IDLE) && !q_empty;
    assign wr_addr   = key_count_reg[kwi_pkg::KEY_IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        key_count_next = key_count_reg;
        last_tick_next = last_tick_reg;
        qtick_next     = qtick_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        hi_tick_next   = hi_tick_reg;
        hi_weight_next = hi_weight_reg;
        span_next      = span_reg;
        elapsed_next   = elapsed_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        left_next      = left_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            kwi_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    res_next.sampled_weight = '0;
                    res_next.status         = kwi_pkg::ST_OK;
                    qtick_next              = head_item.tick;
                    state_next              = kwi_pkg::BK_FINISH;
                    case (head_item.op)
                        kwi_pkg::OP_CLEAR:
                        begin
                            key_count_next = '0;
                        end
                        kwi_pkg::OP_APPEND:
                        begin
                            if (key_count_reg == kwi_pkg::KEY_CNT_MAX)
                            begin
                                res_next.status = kwi_pkg::ST_FULL;
                            end
                            else if (key_count_reg != '0 && head_item.tick <= last_tick_reg)
                            begin
                                res_next.status = kwi_pkg::ST_ORDER;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                last_tick_next = head_item.tick;
                                key_count_next = key_count_reg + 1'b1;
                            end
                        end
                        kwi_pkg::OP_SAMPLE:
                        begin
                            if (key_count_reg == '0)
                            begin
                                res_next.status = kwi_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = key_count_reg;
                                state_next = kwi_pkg::BK_SRCH;
                            end
                        end
                        default:
                        begin
                            res_next.status = kwi_pkg::ST_OK;
                        end
                    endcase
                end
            end
            kwi_pkg::BK_SRCH:
            begin
                rd_en = 1'b1;
                if (lo_reg < hi_reg)
                begin
                    rd_addr    = mid_c[kwi_pkg::KEY_IDX_W-1:0];
                    mid_next   = mid_c;
                    state_next = kwi_pkg::BK_CMP;
                end
                else
                begin
                    if (lo_reg == key_count_reg)
                    begin
                        rd_addr = kwi_pkg::key_idx_t'(key_count_reg - 1'b1);
                    end
                    else
                    begin
                        rd_addr = lo_reg[kwi_pkg::KEY_IDX_W-1:0];
                    end
                    state_next = kwi_pkg::BK_UP;
                end
            end
            kwi_pkg::BK_CMP:
            begin
                if (rd_tick_reg < qtick_reg)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = kwi_pkg::BK_SRCH;
            end
            kwi_pkg::BK_UP:
            begin
                if (lo_reg == '0 || lo_reg == key_count_reg || rd_tick_reg == qtick_reg)
                begin
                    res_next.sampled_weight = rd_weight_reg;
                    state_next              = kwi_pkg::BK_FINISH;
                end
                else
                begin
                    hi_tick_next   = rd_tick_reg;
                    hi_weight_next = rd_weight_reg;
                    rd_en          = 1'b1;
                    rd_addr        = kwi_pkg::key_idx_t'(lo_reg - 1'b1);
                    state_next     = kwi_pkg::BK_LO;
                end
            end
            kwi_pkg::BK_LO:
            begin
                span_next    = hi_tick_reg - rd_tick_reg;
                elapsed_next = qtick_reg - rd_tick_reg;
                neg_next     = (hi_weight_reg < rd_weight_reg);
                mag_next     = (hi_weight_reg < rd_weight_reg) ?
                               rd_weight_reg - hi_weight_reg : hi_weight_reg - rd_weight_reg;
                left_next    = rd_weight_reg;
                state_next   = kwi_pkg::BK_MUL;
            end
            kwi_pkg::BK_MUL:
            begin
                rem_next   = prod[kwi_pkg::PROD_W-1:kwi_pkg::WEIGHT_W];
                dvd_next   = prod[kwi_pkg::WEIGHT_W-1:0];
                quo_next   = '0;
                step_next  = kwi_pkg::STEP_INIT;
                state_next = kwi_pkg::BK_DIV;
            end
            kwi_pkg::BK_DIV:
            begin
                rem_next  = fits ? kwi_pkg::tick_t'(trial - {1'b0, span_reg}) :
                                   trial[kwi_pkg::TICK_W-1:0];
                quo_next  = {quo_reg[kwi_pkg::WEIGHT_W-2:0], fits};
                dvd_next  = dvd_reg << 1;
                step_next = step_reg - 1'b1;
                if (step_reg == kwi_pkg::step_t'(1))
                begin
                    state_next = kwi_pkg::BK_ADJ;
                end
            end
            kwi_pkg::BK_ADJ:
            begin
                res_next.sampled_weight = neg_reg ? left_reg - quo_reg : left_reg + quo_reg;
                state_next              = kwi_pkg::BK_FINISH;
            end
            kwi_pkg::BK_FINISH:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    out_load   = 1'b1;
                    state_next = kwi_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = kwi_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kwi_pkg::BK_IDLE;
            key_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_tick_reg <= last_tick_next;
        qtick_reg     <= qtick_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        hi_tick_reg   <= hi_tick_next;
        hi_weight_reg <= hi_weight_next;
        span_reg      <= span_next;
        elapsed_reg   <= elapsed_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        left_reg      <= left_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        quo_reg       <= quo_next;
        step_reg      <= step_next;
        res_reg       <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    // key store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_ticks_mem[wr_addr]   <= head_item.tick;
            key_weights_mem[wr_addr] <= head_item.weight;
        end
        if (rd_en)
        begin
            rd_tick_reg   <= key_ticks_mem[rd_addr];
            rd_weight_reg <= key_weights_mem[rd_addr];
        end
    end

    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kwi_pkg::BK_CMP) |-> (mid_reg < hi_reg && lo_reg <= mid_reg))
        else $error("search midpoint out of range");

    a_up_in_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kwi_pkg::BK_UP) |-> (lo_reg <= key_count_reg && key_count_reg != '0))
        else $error("search result beyond key count");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kwi_pkg::BK_DIV) |-> (rem_reg < span_reg))
        else $error("divider remainder not below span");

endmodule

/* src/keyframe_weight_interpolator.sv */
// Keyframe weight interpolator: holds up to MAX_KEYS keyframes (tick, weight per
// million) in increasing tick order and answers clear, append and sample commands with
// one result transfer each. A decode stage and a two-entry queue take commands while
// the back end works and a finished result waits in the output register. Clear,
// append and unknown commands go from the idle state straight to finish. A sample
// runs a binary search of at most ceil(log2(key_count + 1)) steps, each a compare
// on a read from the registered key store read port; a sample that lands on a key or
// outside the track then finishes, and an interpolating sample reads the lower key,
// multiplies and runs a restoring divider for all 20 quotient bits. The key store is
// not cleared at reset: a clear only zeroes the key count.
module keyframe_weight_interpolator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  kwi_pkg::cmd_item_t cmd_data,
    output logic               res_valid,
    input  logic               res_stall,
    output kwi_pkg::res_item_t res_data
);

    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    kwi_pkg::op_item_t q_push_item;
    kwi_pkg::op_item_t q_head_item;

    kwi_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd_data    (cmd_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_item (q_push_item)
    );

    kwi_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (q_head_item),
        .empty     (q_empty)
    );

    kwi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (q_head_item),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule
